>>> src/mvm_pkg.sv
`timescale 1ns / 1ps

package mvm_pkg;

  localparam int MAX_COLUMNS_DEF = 64;
  localparam int MAX_ROWS_DEF    = 256;

  localparam int VALUE_W     = 16;
  localparam int INDEX_W     = 6;
  localparam int ROW_INDEX_W = 8;
  localparam int SUM_W       = 40;
  localparam int PROD_W      = 2 * VALUE_W;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 48;

  localparam int COLUMN_COUNT_W = 7;
  localparam int ROW_COUNT_W    = 9;
  localparam int CFG_INDEX_W    = 1;
  localparam int CFG_DATA_W     = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 1'b1;

  localparam logic [COLUMN_COUNT_W-1:0] COLUMN_COUNT_RST = 7'd4;
  localparam logic [ROW_COUNT_W-1:0]    ROW_COUNT_RST    = 9'd8;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_MATRIX = 1'b1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef struct packed {
    logic                    last_row;
    logic signed [SUM_W-1:0] row_sum;
    logic [ROW_INDEX_W-1:0]  row_index;
  } out_word_t;

endpackage

>>> src/matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps

// Streaming matrix-vector multiplier for one dense layer. Vector elements are loaded by
// index (in_tuser low), then matrix elements stream in row-major order (in_tuser high),
// one word per cycle when the result side keeps up.
// Each matrix word is multiplied by the stored vector element of the current column and
// added to a 40-bit Q24.16 accumulator; when a row completes, one result word carries the
// row index, the sum and a last-row flag in tlast. The word that ends a row passes through
// the vector store read, the 16x16 multiplier and the accumulate into a four-entry result
// queue, whose head drives the output directly.
// The input stalls only when that queue, counted with rows still in flight, is full.
// Vector entries must be loaded before they are used; no clearing pass runs after reset.

module matrix_vector_multiply_unit #(
  parameter int MAX_COLUMNS = mvm_pkg::MAX_COLUMNS_DEF,
  parameter int MAX_ROWS    = mvm_pkg::MAX_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // element_index [5:0], value [21:6], zero [23:22]
  input  logic [mvm_pkg::IN_TDATA_W-1:0]        in_tdata,
  // operation
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // row_index [7:0], row_sum [47:8]
  output logic [mvm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic [mvm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [mvm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLIM_W = $clog2(MAX_COLUMNS + 1);
  localparam int RLIM_W = $clog2(MAX_ROWS + 1);

  logic                                  in_op;
  logic [mvm_pkg::INDEX_W-1:0]           in_idx;
  logic signed [mvm_pkg::VALUE_W-1:0]    in_value;
  logic                                  in_acc;
  logic                                  load_acc;
  logic                                  mat_acc;
  logic                                  idx_ok;
  logic [COL_W-1:0]                      ld_addr;

  logic [mvm_pkg::COLUMN_COUNT_W-1:0]    column_count_r;
  logic [mvm_pkg::ROW_COUNT_W-1:0]       row_count_r;

  logic [CLIM_W-1:0]                     cols_lim;
  logic [RLIM_W-1:0]                     rows_lim;
  logic [CLIM_W-1:0]                     col_inc;
  logic [RLIM_W-1:0]                     row_inc;
  logic                                  row_end;
  logic                                  mat_last;

  logic [COL_W-1:0]                      col_cnt_r;
  logic [ROW_W-1:0]                      row_cnt_r;

  logic signed [mvm_pkg::VALUE_W-1:0]    vec_mem [MAX_COLUMNS];

  logic                                  s1_v_r;
  logic                                  s1_end_r;
  logic                                  s1_last_r;
  logic [ROW_W-1:0]                      s1_row_r;
  logic signed [mvm_pkg::VALUE_W-1:0]    s1_a_r;
  logic signed [mvm_pkg::VALUE_W-1:0]    s1_b_r;

  logic                                  s2_v_r;
  logic                                  s2_end_r;
  logic                                  s2_last_r;
  logic [ROW_W-1:0]                      s2_row_r;
  logic signed [mvm_pkg::PROD_W-1:0]     s2_prod_r;

  logic signed [mvm_pkg::SUM_W-1:0]      acc_r;
  logic signed [mvm_pkg::SUM_W-1:0]      acc_sum;

  mvm_pkg::out_word_t                    fifo_mem [mvm_pkg::FIFO_DEPTH];
  mvm_pkg::out_word_t                    push_word;
  mvm_pkg::out_word_t                    head_word;
  logic [mvm_pkg::FIFO_PTR_W-1:0]        wr_ptr_r;
  logic [mvm_pkg::FIFO_PTR_W-1:0]        rd_ptr_r;
  logic [mvm_pkg::FIFO_CNT_W-1:0]        fifo_cnt_r;
  logic [mvm_pkg::FIFO_CNT_W-1:0]        fifo_cnt_nxt;
  logic [mvm_pkg::FIFO_CNT_W-1:0]        credit;
  logic                                  push;
  logic                                  pop;

  assign in_op    = in_tuser;
  assign in_idx   = in_tdata[5:0];
  assign in_value = in_tdata[21:6];

  assign in_acc   = in_tvalid & in_tready;
  assign load_acc = in_acc & (in_op == mvm_pkg::OP_LOAD);
  assign mat_acc  = in_acc & (in_op == mvm_pkg::OP_MATRIX);
  assign idx_ok   = 32'(in_idx) < MAX_COLUMNS;
  assign ld_addr  = COL_W'(in_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= mvm_pkg::COLUMN_COUNT_RST;
      row_count_r    <= mvm_pkg::ROW_COUNT_RST;
    end else if (cfg_we) begin
      priority if (cfg_index == mvm_pkg::CFG_COLUMN_COUNT) begin
        column_count_r <= cfg_wdata[mvm_pkg::COLUMN_COUNT_W-1:0];
      end else if (cfg_index == mvm_pkg::CFG_ROW_COUNT) begin
        row_count_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    priority if (column_count_r == '0) begin
      cols_lim = CLIM_W'(1);
    end else if (32'(column_count_r) > MAX_COLUMNS) begin
      cols_lim = CLIM_W'(MAX_COLUMNS);
    end else begin
      cols_lim = CLIM_W'(column_count_r);
    end
    priority if (row_count_r == '0) begin
      rows_lim = RLIM_W'(1);
    end else if (32'(row_count_r) > MAX_ROWS) begin
      rows_lim = RLIM_W'(MAX_ROWS);
    end else begin
      rows_lim = RLIM_W'(row_count_r);
    end
  end

  assign col_inc  = CLIM_W'(col_cnt_r) + CLIM_W'(1);
  assign row_inc  = RLIM_W'(row_cnt_r) + RLIM_W'(1);
  assign row_end  = col_inc >= cols_lim;
  assign mat_last = row_inc >= rows_lim;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (mat_acc) begin
      if (row_end) begin
        col_cnt_r <= '0;
        row_cnt_r <= mat_last ? '0 : ROW_W'(row_inc);
      end else begin
        col_cnt_r <= COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc && idx_ok) begin
      vec_mem[ld_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_acc) begin
      s1_b_r <= vec_mem[col_cnt_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= mat_acc;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mat_acc) begin
      s1_a_r    <= in_value;
      s1_end_r  <= row_end;
      s1_last_r <= mat_last;
      s1_row_r  <= row_cnt_r;
    end
    s2_prod_r <= s1_a_r * s1_b_r;
    s2_end_r  <= s1_end_r;
    s2_last_r <= s1_last_r;
    s2_row_r  <= s1_row_r;
  end

  assign acc_sum = acc_r + mvm_pkg::SUM_W'(s2_prod_r);
  assign push    = s2_v_r & s2_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (s2_v_r) begin
      acc_r <= s2_end_r ? '0 : acc_sum;
    end
  end

  always_comb begin
    push_word.last_row  = s2_last_r;
    push_word.row_sum   = acc_sum;
    push_word.row_index = mvm_pkg::ROW_INDEX_W'(s2_row_r);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_word;
    end
  end

  assign pop = out_tvalid & out_tready;

  always_comb begin
    unique case ({push, pop})
      2'b10:   fifo_cnt_nxt = fifo_cnt_r + mvm_pkg::FIFO_CNT_W'(1);
      2'b01:   fifo_cnt_nxt = fifo_cnt_r - mvm_pkg::FIFO_CNT_W'(1);
      default: fifo_cnt_nxt = fifo_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      fifo_cnt_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + mvm_pkg::FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + mvm_pkg::FIFO_PTR_W'(1);
      end
      fifo_cnt_r <= fifo_cnt_nxt;
    end
  end

  assign credit = fifo_cnt_r + mvm_pkg::FIFO_CNT_W'(s1_v_r & s1_end_r)
                + mvm_pkg::FIFO_CNT_W'(s2_v_r & s2_end_r);
  assign in_tready = credit < mvm_pkg::FIFO_CNT_W'(mvm_pkg::FIFO_DEPTH);

  assign head_word  = fifo_mem[rd_ptr_r];
  assign out_tvalid = fifo_cnt_r != '0;
  assign out_tdata  = {head_word.row_sum, head_word.row_index};
  assign out_tlast  = head_word.last_row;

endmodule

>>> src/mvm_port_checker.sv
`timescale 1ns / 1ps

module mvm_port_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [mvm_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic                              out_tlast
);

  logic mat_word;

  assign mat_word = in_tvalid && in_tready && (in_tuser == mvm_pkg::OP_MATRIX);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(mat_word, 3))
    else $error("result word without a matrix word three cycles earlier");

endmodule

bind matrix_vector_multiply_unit mvm_port_checker u_mvm_port_checker (.*);

>>> verif/tb_matrix_vector_multiply_unit.sv
`timescale 1ns / 1ps

module tb_matrix_vector_multiply_unit;
  import mvm_pkg::*;

  localparam int NUM_COLUMNS        = MAX_COLUMNS_DEF;
  localparam int NUM_ROWS           = MAX_ROWS_DEF;
  localparam int LATENCY_WAIT       = 8;
  localparam int STALL_LIMIT        = 2000;
  localparam int SENDER_IDLE_SWITCH = 300;
  localparam int NO_IDLE_SWITCH     = 600;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata   = '0;
  logic                    in_tuser   = OP_LOAD;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index  = CFG_COLUMN_COUNT;
  logic [CFG_DATA_W-1:0]   cfg_wdata  = '0;

  logic [VALUE_W-1:0]        vector_copy [NUM_COLUMNS];
  bit                        vector_loaded [NUM_COLUMNS];
  logic signed [SUM_W-1:0]   running_sum      = '0;
  int unsigned               column_pos       = 0;
  int unsigned               row_pos          = 0;
  logic [COLUMN_COUNT_W-1:0] column_count_reg = COLUMN_COUNT_RST;
  logic [ROW_COUNT_W-1:0]    row_count_reg    = ROW_COUNT_RST;
  out_word_t                 row_results_due [$];

  int unsigned words_sent     = 0;
  int unsigned send_idle_pct  = 32;
  int unsigned take_stall_pct = 54;
  int unsigned quiet_cycles   = 0;
  bit          failed         = 1'b0;

  matrix_vector_multiply_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned clamp_limit(input int unsigned reg_value,
                                              input int unsigned max_value);
    if (reg_value == 0) return 1;
    if (reg_value > max_value) return max_value;
    return reg_value;
  endfunction

  function automatic void predict_row_sum(input logic op, input logic [INDEX_W-1:0] idx,
                                          input logic [VALUE_W-1:0] val);
    int unsigned             cols;
    int unsigned             rows;
    int unsigned             col;
    logic signed [SUM_W-1:0] weight;
    logic signed [SUM_W-1:0] element;
    out_word_t               row_done;
    if (op == OP_LOAD) begin
      vector_copy[idx]   = val;
      vector_loaded[idx] = 1'b1;
      return;
    end
    cols        = clamp_limit(column_count_reg, NUM_COLUMNS);
    rows        = clamp_limit(row_count_reg, NUM_ROWS);
    col         = (column_pos >= NUM_COLUMNS) ? NUM_COLUMNS - 1 : column_pos;
    weight      = $signed(val);
    element     = $signed(vector_copy[col]);
    running_sum = running_sum + weight * element;
    if (column_pos + 1 < cols) begin
      column_pos++;
      return;
    end
    row_done.row_index = row_pos[ROW_INDEX_W-1:0];
    row_done.row_sum   = running_sum;
    row_done.last_row  = (row_pos + 1 >= rows);
    row_results_due.push_back(row_done);
    running_sum = '0;
    column_pos  = 0;
    row_pos     = row_done.last_row ? 0 : row_pos + 1;
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return VALUE_W'($urandom_range(511)) - 16'd256;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] val);
    if (words_sent >= NO_IDLE_SWITCH) begin
      send_idle_pct  = 0;
      take_stall_pct = 0;
    end else if (words_sent >= SENDER_IDLE_SWITCH) begin
      send_idle_pct  = 54;
      take_stall_pct = 32;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - VALUE_W - INDEX_W){1'b0}}, val, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_row_sum(op, idx, val);
    words_sent++;
  endtask

  // A matrix word never reads a vector entry that was not loaded since reset.
  task automatic send_matrix_word(input logic [VALUE_W-1:0] val);
    int unsigned col;
    col = (column_pos >= NUM_COLUMNS) ? NUM_COLUMNS - 1 : column_pos;
    if (!vector_loaded[col]) send_word(OP_LOAD, INDEX_W'(col), pick_value());
    send_word(OP_MATRIX, INDEX_W'($urandom), val);
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] cols_data,
                            input logic [CFG_DATA_W-1:0] rows_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_COLUMN_COUNT;
    cfg_wdata <= cols_data;
    @(posedge clk);
    column_count_reg = cols_data[COLUMN_COUNT_W-1:0];
    cfg_index <= CFG_ROW_COUNT;
    cfg_wdata <= rows_data;
    @(posedge clk);
    row_count_reg = rows_data[ROW_COUNT_W-1:0];
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (row_results_due.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic test_load_and_accumulate();
    send_word(OP_LOAD, 6'd0, 16'h8000);
    send_word(OP_LOAD, 6'd1, 16'h7FFF);
    send_word(OP_LOAD, 6'd2, 16'hFFFF);
    send_word(OP_LOAD, 6'd63, 16'h0100);
    send_word(OP_LOAD, 6'd3, 16'h0100);
    send_word(OP_MATRIX, 6'd0, 16'h8000);
    send_word(OP_MATRIX, 6'd63, 16'h8000);
    send_word(OP_MATRIX, 6'd0, 16'h7FFF);
    send_word(OP_MATRIX, 6'd0, 16'h0000);
    send_word(OP_MATRIX, 6'd21, 16'h7FFF);
    send_word(OP_MATRIX, 6'd42, 16'h8000);
    // The entry rewritten here is read by the very next matrix word.
    send_word(OP_LOAD, 6'd2, 16'h7FFF);
    send_word(OP_MATRIX, 6'd0, 16'h7FFF);
    send_word(OP_MATRIX, 6'd0, 16'hFFFF);
    wait_drained();
  endtask

  task automatic test_limits_lowered_mid_row();
    repeat (3) send_matrix_word(pick_value());
    wait_drained();
    write_regs(9'd2, 9'd8);
    repeat (2) send_matrix_word(pick_value());
    wait_drained();
    write_regs(9'd2, 9'd2);
    repeat (5) send_matrix_word(pick_value());
    wait_drained();
  endtask

  task automatic test_register_limits();
    int unsigned phase_cols [6] = '{1, 0, 64, 127, 1, 1};
    int unsigned phase_rows [6] = '{1, 0, 1, 3, 511, 256};
    int unsigned phase_len [6]  = '{6, 4, 64, 64, 260, 4};
    for (int p = 0; p < 6; p++) begin
      write_regs(CFG_DATA_W'(phase_cols[p]), CFG_DATA_W'(phase_rows[p]));
      repeat (phase_len[p]) send_matrix_word(pick_value());
      wait_drained();
    end
  endtask

  task automatic test_random_layers();
    logic [CFG_DATA_W-1:0] cols_data;
    logic [CFG_DATA_W-1:0] rows_data;
    repeat (30) begin
      cols_data = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(6, 1));
      rows_data = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom)
                                           : CFG_DATA_W'($urandom_range(5, 1));
      write_regs(cols_data, rows_data);
      repeat ($urandom_range(24, 8)) begin
        if ($urandom_range(99) < 15) send_word(OP_LOAD, INDEX_W'($urandom), pick_value());
        else send_matrix_word(pick_value());
      end
      wait_drained();
    end
  endtask

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= take_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (row_results_due.size() == 0) begin
        failed = 1'b1;
        $display("%0t ns: expected no word, got row %0d sum %0d last %0b", $time,
                 out_tdata[ROW_INDEX_W-1:0], $signed(out_tdata[ROW_INDEX_W +: SUM_W]),
                 out_tlast);
      end else begin
        want = row_results_due.pop_front();
        if (out_tdata[ROW_INDEX_W-1:0] !== want.row_index ||
            $signed(out_tdata[ROW_INDEX_W +: SUM_W]) !== want.row_sum ||
            out_tlast !== want.last_row) begin
          failed = 1'b1;
          $display("%0t ns: expected row %0d sum %0d last %0b, got row %0d sum %0d last %0b",
                   $time, want.row_index, want.row_sum, want.last_row,
                   out_tdata[ROW_INDEX_W-1:0], $signed(out_tdata[ROW_INDEX_W +: SUM_W]),
                   out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_and_accumulate();
    test_limits_lowered_mid_row();
    test_register_limits();
    test_random_layers();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
